// ----- rtl/json_string_unescape_utf8_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH

// clocked assertion, off while reset is held
`define JSU_ASSERT_ON(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define JSU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

    // input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_t;

    // result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] error_code;
        logic       last;
    } out_t;

    // parser modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX_FIRST,
        MODE_WANT_BSL,
        MODE_WANT_U,
        MODE_HEX_SECOND
    } mode_t;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
    localparam logic [3:0] ERR_CONTROL    = 4'd2;
    localparam logic [3:0] ERR_ESCAPE     = 4'd3;
    localparam logic [3:0] ERR_HEX        = 4'd4;
    localparam logic [3:0] ERR_LONE_LOW   = 4'd5;
    localparam logic [3:0] ERR_NO_LOW     = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW    = 4'd7;
    localparam logic [3:0] ERR_UNTERM     = 4'd8;

    // queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // job handed from the parser to the emitter
    typedef struct packed {
        logic        is_cp;
        logic [20:0] cp;
        logic [7:0]  data;
        logic [1:0]  kind;
        logic [3:0]  code;
    } job_t;

    // queue status towards its neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ----- rtl/jsu_front.sv -----
module jsu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jsu_pkg::in_t  s_data,
    input  jsu_pkg::qstat_t q_stat,
    output logic          q_push,
    output jsu_pkg::job_t q_job
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    mode_t       mode_reg, mode_next;
    logic [11:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  hs_reg, hs_next;
    logic        accept;
    logic [7:0]  c;
    logic [4:0]  dig;
    logic [15:0] v;

    // hex digit value, bit 4 set when the byte is not a digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b0, b[3:0] + 4'd9};
        return r;
    endfunction

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.in_byte;
    assign dig     = hex_value(c);
    assign v       = {acc_reg, dig[3:0]};

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            hs_reg   <= '0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            hs_reg   <= hs_next;
        end
    end

    // next state and job generation
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        hs_next   = hs_reg;
        q_push    = 1'b0;
        q_job     = '{is_cp: 1'b0, cp: '0, data: '0, kind: KIND_BYTE, code: ERR_NONE};
        if (accept) begin
            if (mode_reg == MODE_IDLE) begin
                if (s_data.end_of_input || c != CH_QUOTE) begin
                    q_push     = 1'b1;
                    q_job.kind = KIND_ERR;
                    q_job.code = ERR_NO_QUOTE;
                end else begin
                    mode_next = MODE_BODY;
                end
            end else if (s_data.end_of_input) begin
                q_push     = 1'b1;
                q_job.kind = KIND_ERR;
                q_job.code = ERR_UNTERM;
            end else begin
                case (mode_reg)
                    MODE_BODY: begin
                        if (c == CH_QUOTE) begin
                            mode_next  = MODE_IDLE;
                            q_push     = 1'b1;
                            q_job.kind = KIND_DONE;
                        end else if (c < CH_SPACE) begin
                            q_push     = 1'b1;
                            q_job.kind = KIND_ERR;
                            q_job.code = ERR_CONTROL;
                        end else if (c == CH_BSL) begin
                            mode_next = MODE_ESC;
                        end else begin
                            q_push     = 1'b1;
                            q_job.data = c;
                        end
                    end
                    MODE_ESC: begin
                        mode_next = MODE_BODY;
                        q_push    = 1'b1;
                        case (c)
                            CH_QUOTE, CH_BSL, CH_SLASH: q_job.data = c;
                            CH_B: q_job.data = 8'h08;
                            CH_F: q_job.data = 8'h0c;
                            CH_N: q_job.data = 8'h0a;
                            CH_R: q_job.data = 8'h0d;
                            CH_T: q_job.data = 8'h09;
                            CH_U: begin
                                q_push    = 1'b0;
                                mode_next = MODE_HEX_FIRST;
                                acc_next  = '0;
                                cnt_next  = '0;
                            end
                            default: begin
                                q_job.kind = KIND_ERR;
                                q_job.code = ERR_ESCAPE;
                            end
                        endcase
                    end
                    MODE_WANT_BSL: begin
                        if (c != CH_BSL) begin
                            q_push     = 1'b1;
                            q_job.kind = KIND_ERR;
                            q_job.code = ERR_NO_LOW;
                        end else begin
                            mode_next = MODE_WANT_U;
                        end
                    end
                    MODE_WANT_U: begin
                        if (c != CH_U) begin
                            q_push     = 1'b1;
                            q_job.kind = KIND_ERR;
                            q_job.code = ERR_NO_LOW;
                        end else begin
                            mode_next = MODE_HEX_SECOND;
                            acc_next  = '0;
                            cnt_next  = '0;
                        end
                    end
                    MODE_HEX_FIRST, MODE_HEX_SECOND: begin
                        if (dig[4]) begin
                            q_push     = 1'b1;
                            q_job.kind = KIND_ERR;
                            q_job.code = ERR_HEX;
                        end else if (cnt_reg != 2'd3) begin
                            acc_next = v[11:0];
                            cnt_next = cnt_reg + 2'd1;
                        end else begin
                            acc_next = '0;
                            cnt_next = '0;
                            if (mode_reg == MODE_HEX_FIRST) begin
                                if (v[15:10] == 6'b110110) begin
                                    hs_next   = v[9:0];
                                    mode_next = MODE_WANT_BSL;
                                end else if (v[15:10] == 6'b110111) begin
                                    q_push     = 1'b1;
                                    q_job.kind = KIND_ERR;
                                    q_job.code = ERR_LONE_LOW;
                                end else begin
                                    mode_next   = MODE_BODY;
                                    q_push      = 1'b1;
                                    q_job.is_cp = 1'b1;
                                    q_job.cp    = {5'd0, v};
                                end
                            end else if (v[15:10] != 6'b110111) begin
                                q_push     = 1'b1;
                                q_job.kind = KIND_ERR;
                                q_job.code = ERR_BAD_LOW;
                            end else begin
                                mode_next   = MODE_BODY;
                                hs_next     = '0;
                                q_push      = 1'b1;
                                q_job.is_cp = 1'b1;
                                q_job.cp    = 21'h10000 + {1'b0, hs_reg, v[9:0]};
                            end
                        end
                    end
                    default: begin
                        q_push     = 1'b1;
                        q_job.kind = KIND_ERR;
                        q_job.code = ERR_UNTERM;
                    end
                endcase
            end
            // any error drops the string
            if (q_push && q_job.kind == KIND_ERR) begin
                mode_next = MODE_IDLE;
                acc_next  = '0;
                cnt_next  = '0;
                hs_next   = '0;
            end
        end
    end

endmodule

// ----- rtl/jsu_fifo.sv -----
module jsu_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  jsu_pkg::job_t   wr_job,
    input  logic            pop,
    output jsu_pkg::job_t   rd_job,
    output jsu_pkg::qstat_t stat
);
    import jsu_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_job     = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// ----- rtl/jsu_back.sv -----
module jsu_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  jsu_pkg::job_t   q_job,
    input  jsu_pkg::qstat_t q_stat,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output jsu_pkg::out_t   m_data
);
    import jsu_pkg::*;

    logic       m_valid_reg;
    out_t       m_data_reg;
    logic [1:0] idx_reg;
    logic [1:0] last_idx;
    logic [1:0] rem;
    logic       load;
    logic       take;
    logic       is_last;
    logic [7:0] cp_byte;
    out_t       word;

    // number of utf-8 bytes minus one
    always_comb begin
        if (!q_job.is_cp || q_job.cp <= 21'h7f) last_idx = 2'd0;
        else if (q_job.cp <= 21'h7ff)          last_idx = 2'd1;
        else if (q_job.cp <= 21'hffff)         last_idx = 2'd2;
        else                                   last_idx = 2'd3;
    end

    assign rem     = last_idx - idx_reg;
    assign is_last = (idx_reg == last_idx);
    assign load    = !m_valid_reg || m_ready;
    assign take    = load && !q_stat.empty;
    assign q_pop   = take && is_last;

    // select the byte of the code point at the current position
    always_comb begin
        cp_byte = 8'h00;
        if (idx_reg == 2'd0) begin
            case (last_idx)
                2'd0:    cp_byte = q_job.cp[7:0];
                2'd1:    cp_byte = {3'b110, q_job.cp[10:6]};
                2'd2:    cp_byte = {4'b1110, q_job.cp[15:12]};
                default: cp_byte = {5'b11110, q_job.cp[20:18]};
            endcase
        end else begin
            case (rem)
                2'd0:    cp_byte = {2'b10, q_job.cp[5:0]};
                2'd1:    cp_byte = {2'b10, q_job.cp[11:6]};
                default: cp_byte = {2'b10, q_job.cp[17:12]};
            endcase
        end
    end

    always_comb begin
        word.out_byte   = q_job.is_cp ? cp_byte : q_job.data;
        word.kind       = q_job.is_cp ? KIND_BYTE : q_job.kind;
        word.error_code = q_job.is_cp ? ERR_NONE : q_job.code;
        word.last       = is_last;
    end

    // output register and byte position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (load) m_valid_reg <= !q_stat.empty;
            if (take) idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) m_data_reg <= word;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/json_string_unescape_utf8_unit.sv -----
// JSON string literal unescaper with UTF-8 output.
// Input channel s_*: one raw byte per word, starting at the opening quote;
// end_of_input set marks end of text. Result channel m_*: one word per
// decoded byte, plus a string-closed word or one error word; last marks the
// final result caused by an input byte.
// A parser accepts a byte every cycle while the queue is not full and writes
// at most one job into a four-deep queue; an emitter expands each job into
// one to four result words through a registered output stage.
// An accepted byte's first result word passes through the queue slot and then
// the output register. Throughput: one byte per cycle while each byte gives at
// most one word and the receiver is ready; a \u escape that ends a code point
// gives one UTF-8 byte per emitter cycle (up to four) while the receiver is
// ready, so sustained rate is set by the emitter's output word count. Bytes
// that give no result (opening quote, backslash, hex digits) never enter the queue.
// Reset (aresetn low, synchronous) returns the parser to idle and empties
// the queue and the output register.
// When the receiver stalls, the output word holds; the queue fills and
// s_ready drops once four jobs are waiting.
module json_string_unescape_utf8_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jsu_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output jsu_pkg::out_t m_data
);
    import jsu_pkg::*;

    logic   q_push;
    logic   q_pop;
    job_t   wr_job;
    job_t   rd_job;
    qstat_t q_stat;

    // parser
    jsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_job   (wr_job)
    );

    // job queue
    jsu_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_job  (wr_job),
        .pop     (q_pop),
        .rd_job  (rd_job),
        .stat    (q_stat)
    );

    // emitter
    jsu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_job   (rd_job),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/jsu_checker.sv -----
`include "json_string_unescape_utf8_unit_defines.svh"

module jsu_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input jsu_pkg::out_t m_data
);
    import jsu_pkg::*;

    logic stalled;
    logic term_word;
    logic plain_word;

    // word classes seen on the result channel
    assign stalled    = m_valid && !m_ready;
    assign term_word  = m_valid && (m_data.kind != KIND_BYTE);
    assign plain_word = m_valid && (m_data.kind != KIND_ERR);

    // a stalled result word holds
    `JSU_ASSERT_ON(a_m_hold, aclk, aresetn, stalled |=> m_valid && $stable(m_data), "word not held")

    // reset empties the output
    `JSU_ASSERT_ALWAYS(a_rst_clear, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // reset leaves the input side ready
    `JSU_ASSERT_ALWAYS(a_rst_ready, aclk, !aresetn |=> s_ready, "not ready after reset")

    // string-closed and error words end the results of their byte
    `JSU_ASSERT_ON(a_term_last, aclk, aresetn, term_word |-> m_data.last, "end word without last")

    // error code only on error words
    `JSU_ASSERT_ON(a_code_kind, aclk, aresetn, plain_word |-> m_data.error_code == ERR_NONE, "stray code")

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
